// ===== hdl/ookpe_pkg.sv =====
// Shared types, constants and register codes of the on-off keyed pulse encoder.
`timescale 1ns / 1ps
`default_nettype none
package ookpe_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned NUM_PAIRS   = 9;
	localparam int unsigned PAIR_CNT_W  = $clog2(NUM_PAIRS + 1);
	localparam int unsigned PAIR_IDX_W  = $clog2(NUM_PAIRS);
	localparam int unsigned SEG_W       = PAIR_CNT_W + 1;
	localparam int unsigned DUR_W       = 22;

	localparam logic [1:0] FMT_CLASSIC = 2'd0;
	localparam logic [1:0] FMT_V3      = 2'd1;
	localparam logic [1:0] FMT_BYTE    = 2'd2;

	localparam logic [1:0] REG_FRAME_FORMAT = 2'd0;
	localparam logic [1:0] REG_BASE_PULSE   = 2'd1;
	localparam logic [1:0] REG_LONG_RATIO   = 2'd2;
	localparam logic [1:0] REG_V3_PULSE     = 2'd3;

	localparam logic [15:0] RST_BASE_PULSE = 16'd420;
	localparam logic [3:0]  RST_LONG_RATIO = 4'd3;
	localparam logic [15:0] RST_V3_PULSE   = 16'd275;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_TWO  = 8'h32;

	localparam logic [DUR_W-1:0] FAST_I  = 22'd375;
	localparam logic [DUR_W-1:0] FAST_IF = 22'd1125;
	localparam logic [DUR_W-1:0] FAST_I6 = 22'd2250;
	localparam logic [DUR_W-1:0] SLOW_I  = 22'd510;
	localparam logic [DUR_W-1:0] SLOW_IF = 22'd1020;
	localparam logic [DUR_W-1:0] SLOW_I6 = 22'd3060;

	typedef enum logic [3:0] {
		P_SL,
		P_LS,
		P_SYNC,
		P_START,
		P_UU,
		P_UU5,
		P_STOP,
		P_ONE,
		P_ZERO,
		P_BSYNC
	} pair_t;

	typedef struct packed {
		logic [1:0]  frame_format;
		logic [15:0] base_pulse_us;
		logic [3:0]  long_ratio;
		logic [15:0] v3_pulse_us;
	} cfg_t;

	typedef struct packed {
		pair_t [NUM_PAIRS-1:0]  pairs;
		logic [PAIR_CNT_W-1:0]  npairs;
		logic                   fast;
	} job_t;

endpackage
`default_nettype wire

// ===== hdl/ookpe_front.sv =====
// Front end: accepts frame characters and turns each into a list of pulse pairs.
`timescale 1ns / 1ps
`default_nettype none
module ookpe_front (
	input  wire                 s_tvalid,
	output logic                s_tready,
	input  wire  [15:0]         s_tdata,
	input  wire                 s_tuser,
	input  wire                 s_tlast,
	input  ookpe_pkg::cfg_t     cfg,
	output logic                push_valid,
	input  wire                 push_ready,
	output ookpe_pkg::job_t     push_data
);
	import ookpe_pkg::*;

	logic [7:0] symbol;
	logic [7:0] repeat_index;
	logic       first_of_frame;
	logic       last_of_frame;
	pair_t      sym_a;
	pair_t      sym_b;
	pair_t      bit_pair [8];

	assign symbol         = s_tdata[7:0];
	assign repeat_index   = s_tdata[15:8];
	assign first_of_frame = s_tuser;
	assign last_of_frame  = s_tlast;

	assign s_tready   = push_ready;
	assign push_valid = s_tvalid;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			bit_pair[i] = symbol[7-i] ? P_ONE : P_ZERO;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_PAIRS; i++) begin
			push_data.pairs[i] = P_UU;
		end
		push_data.fast  = (repeat_index[7:2] == 6'd0);
		sym_a = P_UU;
		sym_b = P_UU;
		case (cfg.frame_format)
			FMT_V3: begin
				if (symbol == CH_ZERO) begin
					sym_b = P_UU5;
				end else if (symbol == CH_ONE) begin
					sym_a = P_UU5;
				end
				if (first_of_frame) begin
					push_data.pairs[0] = P_START;
					push_data.pairs[1] = sym_a;
					push_data.pairs[2] = sym_b;
					push_data.pairs[3] = P_STOP;
				end else begin
					push_data.pairs[0] = sym_a;
					push_data.pairs[1] = sym_b;
					push_data.pairs[2] = P_STOP;
				end
				push_data.npairs = PAIR_CNT_W'(2) + PAIR_CNT_W'(first_of_frame)
					+ PAIR_CNT_W'(last_of_frame);
			end
			FMT_BYTE: begin
				if (first_of_frame) begin
					push_data.pairs[0] = P_BSYNC;
					for (int i = 0; i < 8; i++) begin
						push_data.pairs[i+1] = bit_pair[i];
					end
				end else begin
					for (int i = 0; i < 8; i++) begin
						push_data.pairs[i] = bit_pair[i];
					end
				end
				push_data.npairs = PAIR_CNT_W'(8) + PAIR_CNT_W'(first_of_frame);
			end
			default: begin
				if (symbol == CH_ZERO) begin
					sym_a = P_SL;
					sym_b = P_SL;
				end else if (symbol == CH_ONE) begin
					sym_a = P_LS;
					sym_b = P_LS;
				end else if (symbol == CH_TWO) begin
					sym_a = P_LS;
					sym_b = P_SL;
				end else begin
					sym_a = P_SL;
					sym_b = P_LS;
				end
				push_data.pairs[0] = sym_a;
				push_data.pairs[1] = sym_b;
				push_data.pairs[2] = P_SYNC;
				push_data.npairs = PAIR_CNT_W'(2) + PAIR_CNT_W'(last_of_frame);
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/ookpe_queue.sv =====
// Short first-in first-out queue of pulse-pair jobs between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module ookpe_queue #(
	parameter int unsigned DEPTH = ookpe_pkg::QUEUE_DEPTH
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  ookpe_pkg::job_t  push_data,
	output logic             pop_valid,
	input  wire              pop,
	output ookpe_pkg::job_t  pop_data
);
	import ookpe_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ookpe_back.sv =====
// Back end: walks job pulse pairs, emits one timed segment per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module ookpe_back (
	input  wire              clk,
	input  wire              arst_n,
	input  ookpe_pkg::cfg_t  cfg,
	input  wire              pop_valid,
	output logic             pop,
	input  ookpe_pkg::job_t  pop_data,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tlast
);
	import ookpe_pkg::*;

	logic [SEG_W-1:0]      seg_q;
	logic                  out_valid_q;
	logic                  level_q;
	logic [DUR_W-1:0]      dur_q;
	logic                  last_q;
	logic                  advance;
	logic                  fire;
	logic                  seg_last;
	logic                  high_half;
	pair_t                 cur_pair;
	logic [DUR_W-1:0]      dur;
	logic [DUR_W-1:0]      s;
	logic [DUR_W-1:0]      l;
	logic [DUR_W-1:0]      s31;
	logic [DUR_W-1:0]      u;
	logic [DUR_W-1:0]      u5;
	logic [DUR_W-1:0]      u10;
	logic [DUR_W-1:0]      u40;
	logic [DUR_W-1:0]      bi;
	logic [DUR_W-1:0]      bif;
	logic [DUR_W-1:0]      bi6;

	assign advance   = !out_valid_q || m_tready;
	assign fire      = advance && pop_valid;
	assign seg_last  = (seg_q == {pop_data.npairs - 1'b1, 1'b1});
	assign pop       = fire && seg_last;
	assign high_half = !seg_q[0];
	assign cur_pair  = pop_data.pairs[seg_q[SEG_W-1:1]];

	assign s   = DUR_W'(cfg.base_pulse_us);
	assign l   = s * DUR_W'(cfg.long_ratio);
	assign s31 = (s << 5) - s;
	assign u   = DUR_W'(cfg.v3_pulse_us);
	assign u5  = (u << 2) + u;
	assign u10 = (u << 3) + (u << 1);
	assign u40 = (u << 5) + (u << 3);
	assign bi  = pop_data.fast ? FAST_I  : SLOW_I;
	assign bif = pop_data.fast ? FAST_IF : SLOW_IF;
	assign bi6 = pop_data.fast ? FAST_I6 : SLOW_I6;

	always_comb begin
		case (cur_pair)
			P_SL:    dur = high_half ? s : l;
			P_LS:    dur = high_half ? l : s;
			P_SYNC:  dur = high_half ? s : s31;
			P_START: dur = high_half ? s : u10;
			P_UU:    dur = u;
			P_UU5:   dur = high_half ? u : u5;
			P_STOP:  dur = high_half ? u : u40;
			P_ONE:   dur = high_half ? bif : bi;
			P_ZERO:  dur = high_half ? bi : bif;
			P_BSYNC: dur = (high_half && pop_data.fast) ? bi : bi6;
			default: dur = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			level_q <= high_half;
			dur_q   <= dur;
			last_q  <= seg_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= pop_valid;
			end
			if (fire) begin
				seg_q <= seg_last ? '0 : seg_q + 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, dur_q, level_q};
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

// ===== hdl/ook_remote_pulse_encoder_unit.sv =====
// Top level of the on-off keyed remote pulse encoder with its register port.
//
// Channel   Direction  Handshake          Content
// s_*       in         s_tvalid/s_tready  one frame character request
// m_*       out        m_tvalid/m_tready  one carrier segment request
// APB       in         psel/penable       timing and format registers
//
// The back end sequencer emits the segments of a character in order, and a
// character has 4 to 18 segments. The front end accepts a new
// character whenever the job queue has room, also while segments still wait.
// A stall on m_tready holds the output register and the segment counter.
// Reset clears the queue and the sequencer and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module ook_remote_pulse_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = ookpe_pkg::QUEUE_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // symbol [7:0], repeat_index [15:8]
	input  wire         s_tuser,  // first_of_frame
	input  wire         s_tlast,  // last_of_frame
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,  // level [0], duration_us [22:1], zero [23]
	output logic        m_tlast,  // last_segment
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ookpe_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;
	logic       push_valid;
	logic       push_ready;
	job_t       push_data;
	logic       pop_valid;
	logic       pop;
	job_t       pop_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_format  <= FMT_CLASSIC;
			cfg_q.base_pulse_us <= RST_BASE_PULSE;
			cfg_q.long_ratio    <= RST_LONG_RATIO;
			cfg_q.v3_pulse_us   <= RST_V3_PULSE;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FRAME_FORMAT: cfg_q.frame_format  <= pwdata[1:0];
				REG_BASE_PULSE:   cfg_q.base_pulse_us <= pwdata[15:0];
				REG_LONG_RATIO:   cfg_q.long_ratio    <= pwdata[3:0];
				REG_V3_PULSE:     cfg_q.v3_pulse_us   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_FORMAT: prdata = {30'd0, cfg_q.frame_format};
			REG_BASE_PULSE:   prdata = {16'd0, cfg_q.base_pulse_us};
			REG_LONG_RATIO:   prdata = {28'd0, cfg_q.long_ratio};
			REG_V3_PULSE:     prdata = {16'd0, cfg_q.v3_pulse_us};
			default:          prdata = '0;
		endcase
	end

	ookpe_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ookpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	ookpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// ===== bench/ook_remote_pulse_encoder_unit_tb.sv =====
// Self-checking bench for the on-off keyed remote pulse encoder: predicted carrier segments.
`timescale 1ns / 1ps
`default_nettype none
module ook_remote_pulse_encoder_unit_tb;
	import ookpe_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_CHARS = 70;

	typedef struct {
		logic        level;
		logic [21:0] duration_us;
		logic        last_segment;
	} segment_t;

	class pulse_ledger;
		logic [1:0]  frame_format;
		logic [15:0] base_pulse_us;
		logic [3:0]  long_ratio;
		logic [15:0] v3_pulse_us;
		segment_t    due_segments[$];
		segment_t    char_segments[$];
		int          errors;

		function new();
			frame_format  = FMT_CLASSIC;
			base_pulse_us = RST_BASE_PULSE;
			long_ratio    = RST_LONG_RATIO;
			v3_pulse_us   = RST_V3_PULSE;
			errors        = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_FRAME_FORMAT: frame_format = value[1:0];
				REG_BASE_PULSE:   base_pulse_us = value[15:0];
				REG_LONG_RATIO:   long_ratio = value[3:0];
				REG_V3_PULSE:     v3_pulse_us = value[15:0];
				default: ;
			endcase
		endfunction

		function void add_pair(logic [21:0] on_us, logic [21:0] off_us);
			char_segments.push_back('{1'b1, on_us, 1'b0});
			char_segments.push_back('{1'b0, off_us, 1'b0});
		endfunction

		function void take_char(logic [7:0] sym, logic first, logic last, logic [7:0] rep);
			logic [21:0] s, l, u, iv, ivf;
			logic        fast;
			char_segments.delete();
			s = base_pulse_us;
			l = base_pulse_us * long_ratio;
			u = v3_pulse_us;
			case (frame_format)
				FMT_V3: begin
					if (first)
						add_pair(s, u * 10);
					case (sym)
						CH_ZERO: begin
							add_pair(u, u);
							add_pair(u, u * 5);
						end
						CH_ONE: begin
							add_pair(u, u * 5);
							add_pair(u, u);
						end
						default: begin
							add_pair(u, u);
							add_pair(u, u);
						end
					endcase
					if (last)
						add_pair(u, u * 40);
				end
				FMT_BYTE: begin
					fast = rep < 8'd4;
					iv = fast ? FAST_I : SLOW_I;
					ivf = fast ? iv * 3 : iv * 2;
					if (first)
						add_pair(fast ? iv : iv * 6, iv * 6);
					for (int k = 7; k >= 0; k--) begin
						if (sym[k])
							add_pair(ivf, iv);
						else
							add_pair(iv, ivf);
					end
				end
				default: begin
					case (sym)
						CH_ZERO: begin
							add_pair(s, l);
							add_pair(s, l);
						end
						CH_ONE: begin
							add_pair(l, s);
							add_pair(l, s);
						end
						CH_TWO: begin
							add_pair(l, s);
							add_pair(s, l);
						end
						default: begin
							add_pair(s, l);
							add_pair(l, s);
						end
					endcase
					if (last)
						add_pair(s, s * 31);
				end
			endcase
			char_segments[char_segments.size() - 1].last_segment = 1'b1;
			foreach (char_segments[i])
				due_segments.push_back(char_segments[i]);
		endfunction

		function void match_segment(logic level, logic [21:0] duration_us, logic last_segment);
			segment_t want;
			if (due_segments.size() == 0) begin
				$error("unexpected segment: level %0d duration_us %0d last_segment %0d",
					level, duration_us, last_segment);
				errors++;
				return;
			end
			want = due_segments.pop_front();
			if (level !== want.level) begin
				$error("level expected %0d actual %0d", want.level, level);
				errors++;
			end
			if (duration_us !== want.duration_us) begin
				$error("duration_us expected %0d actual %0d", want.duration_us, duration_us);
				errors++;
			end
			if (last_segment !== want.last_segment) begin
				$error("last_segment expected %0d actual %0d", want.last_segment, last_segment);
				errors++;
			end
		endfunction

		function int pending();
			return due_segments.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [23:0] m_tdata;
	wire         m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	pulse_ledger ledger = new();
	bit          quick_send = 1'b0;
	bit          quick_take = 1'b0;
	int          idle_cycles = 0;

	ook_remote_pulse_encoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : segment_sink
		int stall;
		forever begin
			stall = quick_take ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			ledger.match_segment(m_tdata[0], m_tdata[22:1], m_tlast);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		ledger.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic set_timing(input logic [1:0] fmt, input logic [15:0] base,
			input logic [3:0] ratio, input logic [15:0] unit_us);
		write_reg(REG_FRAME_FORMAT, {30'd0, fmt});
		write_reg(REG_BASE_PULSE, {16'd0, base});
		write_reg(REG_LONG_RATIO, {28'd0, ratio});
		write_reg(REG_V3_PULSE, {16'd0, unit_us});
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	task automatic send_char(input logic [7:0] sym, input logic first, input logic last,
			input logic [7:0] rep);
		int gap;
		gap = quick_send ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {rep, sym};
		s_tuser <= first;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		ledger.take_char(sym, first, last, rep);
	endtask

	function automatic logic [15:0] pick_pulse();
		case ($urandom_range(0, 9))
			0: return 16'd1;
			1: return 16'hFFFF;
			2: return 16'd0;
			default: return 16'($urandom_range(1, 1000));
		endcase
	endfunction

	initial begin : stimulus
		logic [7:0] chars[3];
		logic [7:0] sym;
		logic [7:0] rep;
		logic       first;
		logic       last;
		int         random_sent;
		int         phase_len;
		int         done;
		int         frame_len;
		chars = '{CH_ZERO, CH_ONE, CH_TWO};
		random_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults, classic tristate with every symbol kind.
		send_char(CH_ZERO, 1'b1, 1'b0, 8'd0);
		send_char(CH_ONE, 1'b0, 1'b0, 8'd255);
		send_char(CH_TWO, 1'b0, 1'b0, 8'd0);
		send_char(8'h46, 1'b0, 1'b1, 8'd0);
		send_char(8'h00, 1'b0, 1'b1, 8'd0);
		send_char(8'hFF, 1'b1, 1'b0, 8'd170);

		wait_idle();
		set_timing(FMT_V3, 16'd420, 4'd3, 16'd275);
		send_char(CH_ZERO, 1'b1, 1'b0, 8'd0);
		send_char(CH_ONE, 1'b0, 1'b0, 8'd0);
		send_char(CH_TWO, 1'b0, 1'b1, 8'd0);
		send_char(CH_ZERO, 1'b1, 1'b1, 8'd0);

		// Byte mode on both sides of the fast timing boundary.
		wait_idle();
		set_timing(FMT_BYTE, 16'd420, 4'd3, 16'd275);
		send_char(8'hA5, 1'b1, 1'b0, 8'd0);
		send_char(8'h5A, 1'b0, 1'b0, 8'd3);
		send_char(8'hFF, 1'b1, 1'b1, 8'd4);
		send_char(8'h00, 1'b0, 1'b1, 8'd255);

		// The spare format code falls back to classic; largest timing values.
		wait_idle();
		set_timing(2'd3, 16'hFFFF, 4'd15, 16'hFFFF);
		send_char(CH_TWO, 1'b0, 1'b1, 8'd0);
		send_char(CH_ZERO, 1'b1, 1'b1, 8'd0);
		send_char(8'h55, 1'b0, 1'b0, 8'd0);

		wait_idle();
		set_timing(FMT_V3, 16'hFFFF, 4'd15, 16'hFFFF);
		send_char(CH_ONE, 1'b1, 1'b1, 8'd0);

		// Zero timing registers give zero durations.
		wait_idle();
		set_timing(FMT_V3, 16'd0, 4'd0, 16'd0);
		send_char(CH_ZERO, 1'b1, 1'b1, 8'd0);
		wait_idle();
		set_timing(FMT_CLASSIC, 16'd1234, 4'd0, 16'd0);
		send_char(8'h46, 1'b0, 1'b1, 8'd0);
		send_char(CH_ONE, 1'b0, 1'b1, 8'd0);

		while (random_sent < RANDOM_CHARS) begin
			wait_idle();
			quick_send = ($urandom_range(0, 3) == 0);
			quick_take = ($urandom_range(0, 3) == 0);
			set_timing(2'($urandom_range(0, 3)), pick_pulse(), 4'($urandom_range(0, 15)),
				pick_pulse());
			phase_len = $urandom_range(12, 24);
			done = 0;
			while (done < phase_len) begin
				frame_len = $urandom_range(1, 6);
				rep = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
				for (int p = 0; p < frame_len; p++) begin
					first = (p == 0);
					last = (p == frame_len - 1);
					if ($urandom_range(0, 7) == 0) begin
						first = 1'($urandom_range(0, 1));
						last = 1'($urandom_range(0, 1));
					end
					sym = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
						: chars[$urandom_range(0, 2)];
					if ($urandom_range(0, 15) == 0)
						wait_idle();
					send_char(sym, first, last, rep);
					done++;
				end
			end
			random_sent += done;
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
